@@ design/assert_macros.svh @@
// Assertion macros used by the checker module of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DMW_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define DMW_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ design/dmwtc_pkg.sv @@
// Shared constants and controller/datapath interface types of the cache.
package dmwtc_pkg;

	localparam int ADDR_BITS = 12;
	localparam int DATA_BITS = 32;

	localparam int DEF_LINES        = 8;
	localparam int DEF_MEMORY_WORDS = 1024;
	localparam int DEF_BLOCK_BYTES  = 4;
	localparam int DEF_WORD_BITS    = 32;

	typedef struct packed {
		logic clear;
		logic accept;
		logic step_a;
		logic step_b;
		logic step_c;
		logic read;
		logic commit;
	} dmwtc_cmd_t;

	typedef struct packed {
		logic clear_last;
	} dmwtc_sts_t;

endpackage

@@ design/direct_mapped_write_through_cache_core.sv @@
// Top level of the direct-mapped write-through cache with its backing memory.
// Requests arrive on req_valid/req_ready with func (0 read, 1 store),
// byte_address and write_data; each request yields exactly one response on
// rsp_valid/rsp_ready carrying the line's word after the access and a hit flag
// (hit is 1 only for a read that found a valid line with a matching tag).
// An accepted request passes through the address-split steps (block, then tag
// and memory quotient by constant reciprocals, then index by subtraction), a
// registered line-store and memory read step, and a compare and write-back
// step. Requests are taken one at a time: a new request is accepted only after
// the last one has left its write-back step.
// The response sits in an output register; a new request is accepted while an
// earlier response waits, and it holds in its final step until the receiver
// takes that response.
// After reset a clearing pass over max(LINES, MEMORY_WORDS) entries invalidates
// every line and loads memory word i with i; req_ready stays low meanwhile.
module direct_mapped_write_through_cache_core import dmwtc_pkg::*; #(
	parameter int LINES        = DEF_LINES,
	parameter int MEMORY_WORDS = DEF_MEMORY_WORDS,
	parameter int BLOCK_BYTES  = DEF_BLOCK_BYTES,
	parameter int WORD_BITS    = DEF_WORD_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  logic                 func,
	input  logic [ADDR_BITS-1:0] byte_address,
	input  logic [DATA_BITS-1:0] write_data,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output logic [DATA_BITS-1:0] read_data,
	output logic                 hit
);

	dmwtc_cmd_t cmd;
	dmwtc_sts_t sts;

	dmwtc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	dmwtc_datapath #(
		.LINES        (LINES),
		.MEMORY_WORDS (MEMORY_WORDS),
		.BLOCK_BYTES  (BLOCK_BYTES),
		.WORD_BITS    (WORD_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.func         (func),
		.byte_address (byte_address),
		.write_data   (write_data),
		.read_data    (read_data),
		.hit          (hit)
	);

endmodule

@@ design/dmwtc_ctrl.sv @@
// Controller state machine: clearing pass, request sequencing and response flag.
module dmwtc_ctrl import dmwtc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	input  dmwtc_sts_t sts,
	output dmwtc_cmd_t cmd
);

	localparam logic [2:0] ST_INIT   = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_DIVA   = 3'd2;
	localparam logic [2:0] ST_DIVB   = 3'd3;
	localparam logic [2:0] ST_DIVC   = 3'd4;
	localparam logic [2:0] ST_READ   = 3'd5;
	localparam logic [2:0] ST_COMMIT = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       rsp_valid_q;

	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		state_d   = state_q;
		unique case (state_q)
			ST_INIT: begin
				cmd.clear = 1'b1;
				if (sts.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_DIVA;
				end
			end
			ST_DIVA: begin
				cmd.step_a = 1'b1;
				state_d    = ST_DIVB;
			end
			ST_DIVB: begin
				cmd.step_b = 1'b1;
				state_d    = ST_DIVC;
			end
			ST_DIVC: begin
				cmd.step_c = 1'b1;
				state_d    = ST_READ;
			end
			ST_READ: begin
				cmd.read = 1'b1;
				state_d  = ST_COMMIT;
			end
			ST_COMMIT: begin
				// The result waits here until the output register is free.
				if (!rsp_valid_q || rsp_ready) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_INIT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule

@@ design/dmwtc_datapath.sv @@
// Datapath: address split, line store, backing memory and response register.
module dmwtc_datapath import dmwtc_pkg::*; #(
	parameter int LINES        = DEF_LINES,
	parameter int MEMORY_WORDS = DEF_MEMORY_WORDS,
	parameter int BLOCK_BYTES  = DEF_BLOCK_BYTES,
	parameter int WORD_BITS    = DEF_WORD_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dmwtc_cmd_t           cmd,
	output dmwtc_sts_t           sts,
	input  logic                 func,
	input  logic [ADDR_BITS-1:0] byte_address,
	input  logic [DATA_BITS-1:0] write_data,
	output logic [DATA_BITS-1:0] read_data,
	output logic                 hit
);

	localparam int MAX_BLOCK  = ((1 << ADDR_BITS) - 1) / BLOCK_BYTES;
	localparam int BLOCK_BITS = (MAX_BLOCK > 0) ? $clog2(MAX_BLOCK + 1) : 1;
	localparam int MAX_TAG    = MAX_BLOCK / LINES;
	localparam int TAG_BITS   = (MAX_TAG > 0) ? $clog2(MAX_TAG + 1) : 1;
	localparam int MAX_MEMQ   = MAX_BLOCK / MEMORY_WORDS;
	localparam int MEMQ_BITS  = (MAX_MEMQ > 0) ? $clog2(MAX_MEMQ + 1) : 1;
	localparam int LINE_BITS  = (LINES > 1) ? $clog2(LINES) : 1;
	localparam int MEM_BITS   = $clog2(MEMORY_WORDS);
	localparam int LINE_W     = 1 + TAG_BITS + WORD_BITS;

	localparam int CLR_COUNT  = (LINES > MEMORY_WORDS) ? LINES : MEMORY_WORDS;
	localparam int CLR_BITS   = $clog2(CLR_COUNT);

	// Quotients by constants come from a rounded-up reciprocal and a shift;
	// with a shift of N plus ceil(log2 d) the result is exact for N-bit values.
	localparam int BLK_SHIFT = ADDR_BITS + $clog2(BLOCK_BYTES);
	localparam longint unsigned BLK_RECIP =
		((64'd1 << BLK_SHIFT) + BLOCK_BYTES - 1) / BLOCK_BYTES;
	localparam int BLK_PW = ADDR_BITS + BLK_SHIFT + 1;

	localparam int LIN_SHIFT = BLOCK_BITS + $clog2(LINES);
	localparam longint unsigned LIN_RECIP =
		((64'd1 << LIN_SHIFT) + LINES - 1) / LINES;
	localparam int LIN_PW = BLOCK_BITS + LIN_SHIFT + 1;

	localparam int MEM_SHIFT = BLOCK_BITS + $clog2(MEMORY_WORDS);
	localparam longint unsigned MEM_RECIP =
		((64'd1 << MEM_SHIFT) + MEMORY_WORDS - 1) / MEMORY_WORDS;
	localparam int MEM_PW = BLOCK_BITS + MEM_SHIFT + 1;

	localparam int W_A  = (BLOCK_BITS > MEM_BITS) ? BLOCK_BITS : MEM_BITS;
	localparam int RW   = (W_A > LINE_BITS) ? W_A : LINE_BITS;
	localparam int XW   = (WORD_BITS > DATA_BITS) ? WORD_BITS : DATA_BITS;
	localparam int CW   = (WORD_BITS > CLR_BITS) ? WORD_BITS : CLR_BITS;

	// Request registers.
	logic                 func_q;
	logic [ADDR_BITS-1:0] addr_q;
	logic [DATA_BITS-1:0] wdata_q;

	// Address split pipeline.
	logic [BLOCK_BITS-1:0] block_s1;
	logic [BLOCK_BITS-1:0] block_s2;
	logic [TAG_BITS-1:0]   tag_s2;
	logic [MEMQ_BITS-1:0]  memq_s2;
	logic [LINE_BITS-1:0]  idx_s3;
	logic [MEM_BITS-1:0]   midx_s3;

	logic [BLK_PW-1:0] blk_prod;
	logic [LIN_PW-1:0] lin_prod;
	logic [MEM_PW-1:0] mem_prod;
	logic [RW-1:0]     idx_full;
	logic [RW-1:0]     midx_full;

	// Storage.
	logic [LINE_W-1:0]    line_mem [LINES];
	logic [WORD_BITS-1:0] back_mem [MEMORY_WORDS];
	logic [LINE_W-1:0]    line_rd_q;
	logic [WORD_BITS-1:0] mem_rd_q;
	logic [CLR_BITS-1:0]  clr_q;

	logic                 line_we;
	logic [LINE_BITS-1:0] line_waddr;
	logic [LINE_W-1:0]    line_wdata;
	logic                 mem_we;
	logic [MEM_BITS-1:0]  mem_waddr;
	logic [WORD_BITS-1:0] mem_wdata;

	logic                 rd_valid;
	logic [TAG_BITS-1:0]  rd_tag;
	logic [WORD_BITS-1:0] rd_word;
	logic                 hit_now;
	logic [XW-1:0]        wd_ext;
	logic [WORD_BITS-1:0] wd_word;
	logic [WORD_BITS-1:0] new_word;
	logic [XW-1:0]        out_ext;
	logic [CW-1:0]        clr_ext;
	logic                 clr_in_lines;
	logic                 clr_in_mem;

	logic [DATA_BITS-1:0] read_data_q;
	logic                 hit_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			func_q  <= func;
			addr_q  <= byte_address;
			wdata_q <= write_data;
		end
	end

	assign blk_prod = BLK_PW'(addr_q) * BLK_PW'(BLK_RECIP);
	assign lin_prod = LIN_PW'(block_s1) * LIN_PW'(LIN_RECIP);
	assign mem_prod = MEM_PW'(block_s1) * MEM_PW'(MEM_RECIP);

	// The remainders are exact and never exceed the block address, so the
	// wrap-around arithmetic in RW bits gives the true value.
	assign idx_full  = RW'(block_s2) - RW'(tag_s2) * RW'(LINES);
	assign midx_full = RW'(block_s2) - RW'(memq_s2) * RW'(MEMORY_WORDS);

	always_ff @(posedge clk) begin
		if (cmd.step_a) begin
			block_s1 <= blk_prod[BLK_SHIFT +: BLOCK_BITS];
		end
		if (cmd.step_b) begin
			block_s2 <= block_s1;
			tag_s2   <= lin_prod[LIN_SHIFT +: TAG_BITS];
			memq_s2  <= mem_prod[MEM_SHIFT +: MEMQ_BITS];
		end
		if (cmd.step_c) begin
			idx_s3  <= idx_full[LINE_BITS-1:0];
			midx_s3 <= midx_full[MEM_BITS-1:0];
		end
	end

	// Clearing pass after reset: line entries go invalid, memory word i gets i.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear && !sts.clear_last) begin
			clr_q <= clr_q + CLR_BITS'(1);
		end
	end

	assign sts.clear_last = (clr_q == CLR_BITS'(CLR_COUNT - 1));
	assign clr_in_lines   = ({1'b0, clr_q} < (CLR_BITS + 1)'(LINES));
	assign clr_in_mem     = ({1'b0, clr_q} < (CLR_BITS + 1)'(MEMORY_WORDS));
	assign clr_ext        = CW'(clr_q);

	assign rd_valid = line_rd_q[LINE_W-1];
	assign rd_tag   = line_rd_q[WORD_BITS +: TAG_BITS];
	assign rd_word  = line_rd_q[WORD_BITS-1:0];
	assign hit_now  = !func_q && rd_valid && (rd_tag == tag_s2);

	assign wd_ext   = XW'(wdata_q);
	assign wd_word  = wd_ext[WORD_BITS-1:0];
	assign new_word = func_q ? wd_word : (hit_now ? rd_word : mem_rd_q);
	assign out_ext  = XW'(new_word);

	assign line_we    = (cmd.clear && clr_in_lines) || (cmd.commit && !hit_now);
	assign line_waddr = cmd.clear ? clr_q[LINE_BITS-1:0] : idx_s3;
	assign line_wdata = cmd.clear ? '0 : {1'b1, tag_s2, new_word};

	assign mem_we    = (cmd.clear && clr_in_mem) || (cmd.commit && func_q);
	assign mem_waddr = cmd.clear ? clr_q[MEM_BITS-1:0] : midx_s3;
	assign mem_wdata = cmd.clear ? clr_ext[WORD_BITS-1:0] : new_word;

	always_ff @(posedge clk) begin
		if (line_we) begin
			line_mem[line_waddr] <= line_wdata;
		end
		if (cmd.read) begin
			line_rd_q <= line_mem[idx_s3];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			back_mem[mem_waddr] <= mem_wdata;
		end
		if (cmd.read) begin
			mem_rd_q <= back_mem[midx_s3];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			read_data_q <= out_ext[DATA_BITS-1:0];
			hit_q       <= hit_now;
		end
	end

	assign read_data = read_data_q;
	assign hit       = hit_q;

endmodule

@@ design/dmwtc_checker.sv @@
// Port-level assertions for the cache core and the bind that attaches them.
`include "assert_macros.svh"

module dmwtc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [31:0] read_data,
	input logic        hit
);

	// Requests are served one at a time.
	`DMW_NEXT(a_one_request, clk, arst_n, req_valid && req_ready, !req_ready)

	// A response only appears from a request in progress.
	`DMW_IMPLY(a_rsp_from_work, clk, arst_n, $rose(rsp_valid), $past(!req_ready))

	// A stalled response keeps its contents.
	`DMW_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(read_data) && $stable(hit))

endmodule

bind direct_mapped_write_through_cache_core dmwtc_checker u_dmwtc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.read_data (read_data),
	.hit       (hit)
);

@@ bench/direct_mapped_write_through_cache_core_test.sv @@
// Self-checking testbench for the direct-mapped write-through cache core.
module direct_mapped_write_through_cache_core_test import dmwtc_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic FUNC_READ  = 1'b0;
	localparam logic FUNC_STORE = 1'b1;

	localparam int TAG_COUNT = DEF_MEMORY_WORDS / DEF_LINES;

	typedef struct {
		logic [DATA_BITS-1:0] data;
		logic                 hit;
	} cache_result_t;

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 req_valid    = 1'b0;
	logic                 req_ready;
	logic                 func         = FUNC_READ;
	logic [ADDR_BITS-1:0] byte_address = '0;
	logic [DATA_BITS-1:0] write_data   = '0;
	logic                 rsp_valid;
	logic                 rsp_ready    = 1'b0;
	logic [DATA_BITS-1:0] read_data;
	logic                 hit;

	// Shadow copy of the cache lines and the backing memory.
	logic                 shadow_valid [DEF_LINES];
	int                   shadow_tag   [DEF_LINES];
	logic [DATA_BITS-1:0] shadow_word  [DEF_LINES];
	logic [DATA_BITS-1:0] shadow_mem   [DEF_MEMORY_WORDS];

	cache_result_t pending_results[$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int error_count   = 0;
	int read_count    = 0;
	int store_count   = 0;
	int hit_count     = 0;
	int hot_tag[4];

	direct_mapped_write_through_cache_core i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.func        (func),
		.byte_address(byte_address),
		.write_data  (write_data),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.read_data   (read_data),
		.hit         (hit)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	function automatic cache_result_t cache_lookup(input logic kind,
			input logic [ADDR_BITS-1:0] addr, input logic [DATA_BITS-1:0] data);
		int blk;
		int idx;
		int tag;
		int widx;
		cache_result_t r;
		blk  = int'(addr) / DEF_BLOCK_BYTES;
		idx  = blk % DEF_LINES;
		tag  = blk / DEF_LINES;
		widx = blk % DEF_MEMORY_WORDS;
		r.hit = 1'b0;
		if (kind == FUNC_STORE) begin
			shadow_mem[widx]  = data;
			shadow_word[idx]  = data;
			shadow_tag[idx]   = tag;
			shadow_valid[idx] = 1'b1;
		end else if (shadow_valid[idx] && shadow_tag[idx] == tag) begin
			r.hit = 1'b1;
		end else begin
			shadow_tag[idx]   = tag;
			shadow_valid[idx] = 1'b1;
			shadow_word[idx]  = shadow_mem[widx];
		end
		r.data = shadow_word[idx];
		return r;
	endfunction

	// Called right after a rising edge; returns at the edge that accepts the request.
	task automatic send_access(input logic kind, input logic [ADDR_BITS-1:0] addr,
			input logic [DATA_BITS-1:0] data);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid    <= 1'b1;
		func         <= kind;
		byte_address <= addr;
		write_data   <= data;
		do @(posedge clk); while (!req_ready);
		pending_results.push_back(cache_lookup(kind, addr, data));
		if (kind == FUNC_STORE)
			store_count++;
		else
			read_count++;
	endtask

	always @(posedge clk) begin : check_responses
		cache_result_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (hit === 1'b1)
				hit_count++;
			if (pending_results.size() == 0) begin
				$error("response arrived with no request outstanding");
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (read_data !== want.data) begin
					$error("read_data: expected %h, actual %h", want.data, read_data);
					error_count++;
				end
				if (hit !== want.hit) begin
					$error("hit: expected %b, actual %b", want.hit, hit);
					error_count++;
				end
			end
		end
	end

	// Memory should hold its index after the clearing pass and every line starts invalid.
	task automatic test_reset_contents();
		send_access(FUNC_READ, 12'h000, $urandom);
		send_access(FUNC_READ, 12'hfff, $urandom);
		send_access(FUNC_READ, 12'h000, $urandom);
		send_access(FUNC_READ, 12'h003, $urandom);
		send_access(FUNC_READ, 12'h7fe, $urandom);
	endtask

	task automatic test_store_then_load();
		send_access(FUNC_STORE, 12'h004, 32'hffffffff);
		send_access(FUNC_READ,  12'h005, 32'h00000000);
		send_access(FUNC_STORE, 12'hffc, 32'h00000000);
		send_access(FUNC_READ,  12'hffe, 32'hffffffff);
		send_access(FUNC_STORE, 12'h020, 32'ha5a5a5a5);
		send_access(FUNC_READ,  12'h000, 32'h5a5a5a5a);
		send_access(FUNC_READ,  12'h020, 32'h00000000);
	endtask

	// Lines that share an index evict each other; a store to a resident line still reports no hit.
	task automatic test_conflicts();
		send_access(FUNC_READ,  12'h040, 32'h0);
		send_access(FUNC_READ,  12'h041, 32'h0);
		send_access(FUNC_STORE, 12'h040, 32'h12345678);
		send_access(FUNC_READ,  12'h042, 32'h0);
		send_access(FUNC_STORE, 12'h860, 32'h87654321);
		send_access(FUNC_READ,  12'h043, 32'h0);
		send_access(FUNC_READ,  12'h863, 32'h0);
		send_access(FUNC_STORE, 12'h001, 32'h55555555);
	endtask

	task automatic test_random_traffic(input int count);
		int blk;
		logic kind;
		logic [ADDR_BITS-1:0] addr;
		for (int i = 0; i < 4; i++)
			hot_tag[i] = $urandom_range(TAG_COUNT - 1);
		for (int n = 0; n < count; n++) begin
			kind = ($urandom_range(99) < 40) ? FUNC_STORE : FUNC_READ;
			// Mostly a small working set so that hits and evictions both happen often.
			if ($urandom_range(99) < 75) begin
				blk  = hot_tag[$urandom_range(3)] * DEF_LINES + $urandom_range(DEF_LINES - 1);
				addr = ADDR_BITS'(blk * DEF_BLOCK_BYTES + $urandom_range(DEF_BLOCK_BYTES - 1));
			end else begin
				addr = ADDR_BITS'($urandom);
			end
			send_access(kind, addr, $urandom);
		end
	endtask

	initial begin
		for (int i = 0; i < DEF_LINES; i++) begin
			shadow_valid[i] = 1'b0;
			shadow_tag[i]   = 0;
			shadow_word[i]  = '0;
		end
		for (int i = 0; i < DEF_MEMORY_WORDS; i++)
			shadow_mem[i] = DATA_BITS'(i);

		send_idle_pct = 30;
		recv_idle_pct = 86;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_contents();
		test_store_then_load();
		test_conflicts();

		test_random_traffic(520);
		send_idle_pct = 86;
		recv_idle_pct = 30;
		test_random_traffic(520);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_traffic(520);
		req_valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Ran %0d reads and %0d stores; %0d reads hit in the cache.",
			read_count, store_count, hit_count);
		$display("Traffic covered sender and receiver stalls in both balances and a stall-free run.");
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("Timed out with %0d responses outstanding.", pending_results.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
